FILE: hdl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and codes for the minimum-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int unsigned IdW    = 16;
  localparam int unsigned HoursW = 12;

  // operation codes carried in tuser; the unused code behaves as a query
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_UNDER = 2'd1;
  localparam logic [1:0] STAT_OVER  = 2'd2;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [HoursW-1:0] hours;
  } rec_t;

  // controller to datapath
  typedef struct packed {
    logic take;        // input word accepted this cycle
    logic load_top;    // reload top record after a pop
    logic load_least;  // reload minimum record after a pop
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic reload;      // current input word is a pop that leaves records behind
  } dp_stat_t;

endpackage

FILE: hdl/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// Sequencer for the minimum-tracking stack: input handshake, pop reload
// steps and the output valid flag.
// ----------------------------------------------------------------------------
module mts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  input  mts_pkg::dp_stat_t stat_i,
  output mts_pkg::dp_cmd_t  cmd_o
);
  import mts_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD_TOP,
    ST_LOAD_LEAST
  } state_e;

  state_e state_q;
  logic   m_valid_q;
  logic   take;
  logic   res_done;

  always_comb begin
    s_ready_o         = (state_q == ST_IDLE) && (!m_valid_q || m_ready_i);
    take              = s_valid_i && s_ready_o;
    // result register completes a word this cycle
    res_done          = (take && !stat_i.reload) || (state_q == ST_LOAD_LEAST);
    cmd_o.take        = take;
    cmd_o.load_top    = (state_q == ST_LOAD_TOP);
    cmd_o.load_least  = (state_q == ST_LOAD_LEAST);
  end

  assign m_valid_o = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      if (res_done) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (take && stat_i.reload) begin
            state_q <= ST_LOAD_TOP;
          end
        end
        ST_LOAD_TOP: begin
          state_q <= ST_LOAD_LEAST;
        end
        ST_LOAD_LEAST: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/mts_dp.sv
// ----------------------------------------------------------------------------
// mts_dp
// Datapath of the minimum-tracking stack: record store, minimum-position
// store, fill count, cached top and minimum records, result register.
// ----------------------------------------------------------------------------
module mts_dp #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned FW   = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        kind_i,
  input  mts_pkg::rec_t     rec_i,
  input  mts_pkg::dp_cmd_t  cmd_i,
  output mts_pkg::dp_stat_t stat_o,
  output mts_pkg::rec_t     item_o,
  output mts_pkg::rec_t     least_o,
  output logic [FW-1:0]     depth_o,
  output logic [1:0]        status_o
);
  import mts_pkg::*;

  rec_t          ent_mem  [DEPTH];
  logic [AW-1:0] lpos_mem [DEPTH];

  logic [FW-1:0] fill_q, fill_d;
  rec_t          top_q, least_q;
  logic [AW-1:0] least_idx_q;
  rec_t          ent_rd_q;
  logic [AW-1:0] lpos_rd_q;

  rec_t          item_q, least_out_q;
  logic [FW-1:0] depth_q;
  logic [1:0]    status_q;

  logic          fill_zero, fill_one, fill_full;
  logic          push_ok, new_min;
  logic [AW-1:0] top_addr, under_addr, ent_rd_addr, push_lpos;
  logic [FW-1:0] under_fill;
  rec_t          res_item, res_least;
  logic [1:0]    res_status;

  always_comb begin
    fill_zero   = (fill_q == '0);
    fill_one    = (fill_q == FW'(1));
    fill_full   = (fill_q == FW'(DEPTH));
    top_addr    = fill_q[AW-1:0];
    under_fill  = fill_q - FW'(2);
    under_addr  = under_fill[AW-1:0];
    ent_rd_addr = cmd_i.load_top ? lpos_rd_q : under_addr;
    push_ok     = (kind_i == KIND_PUSH) && !fill_full;
    new_min     = fill_zero || (rec_i.hours <= least_q.hours);
    push_lpos   = new_min ? top_addr : least_idx_q;
    stat_o.reload = (kind_i == KIND_POP) && !fill_zero && !fill_one;

    fill_d     = fill_q;
    res_item   = top_q;
    res_least  = least_q;
    res_status = STAT_OK;
    unique case (kind_i)
      KIND_PUSH: begin
        if (fill_full) begin
          res_status = STAT_OVER;
        end else begin
          fill_d    = fill_q + FW'(1);
          res_item  = rec_i;
          res_least = new_min ? rec_i : least_q;
        end
      end
      KIND_POP: begin
        if (fill_zero) begin
          res_status = STAT_UNDER;
          res_item   = '0;
        end else begin
          fill_d = fill_q - FW'(1);
        end
      end
      default: begin
        if (fill_zero) begin
          res_status = STAT_UNDER;
          res_item   = '0;
        end
      end
    endcase
    if (fill_d == '0) begin
      res_least = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.take) begin
      fill_q <= fill_d;
    end
  end

  // stores: one write at the top, registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && push_ok) begin
      ent_mem[top_addr]  <= rec_i;
      lpos_mem[top_addr] <= push_lpos;
    end
    ent_rd_q  <= ent_mem[ent_rd_addr];
    lpos_rd_q <= lpos_mem[under_addr];
  end

  // cached top and minimum records
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && push_ok) begin
      top_q <= rec_i;
      if (new_min) begin
        least_q     <= rec_i;
        least_idx_q <= top_addr;
      end
    end
    if (cmd_i.load_top) begin
      top_q       <= ent_rd_q;
      least_idx_q <= lpos_rd_q;
    end
    if (cmd_i.load_least) begin
      least_q <= ent_rd_q;
    end
  end

  // result register; the minimum fields are patched after a pop reload
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      item_q      <= res_item;
      least_out_q <= res_least;
      depth_q     <= fill_d;
      status_q    <= res_status;
    end
    if (cmd_i.load_least) begin
      least_out_q <= ent_rd_q;
    end
  end

  assign item_o   = item_q;
  assign least_o  = least_out_q;
  assign depth_o  = depth_q;
  assign status_o = status_q;

endmodule

FILE: hdl/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// min_tracking_stack
// Bounded LIFO stack of (id, hours) records that reports the minimum-hours
// record on every operation.
// ----------------------------------------------------------------------------
// Each input word pushes a record, pops the top record or queries (code 3 acts
// as a query), and yields exactly one output word: the pushed, popped or top
// record, the stored record with the fewest hours after the operation (ties
// go to the most recently pushed), the depth and a status (ok, underflow,
// overflow with the push dropped). Push, query, underflow, overflow and a pop
// that empties the stack load the result register directly from the word.
// A pop that leaves records behind then holds off input through the LOAD_TOP
// and LOAD_LEAST states, as the record store has a single read port: one read
// fetches the new top record and its minimum position, a second read fetches
// the minimum record itself. A single output register holds the result, so a
// new word is taken only while that register is empty or its word leaves in
// the same cycle. Store contents need no clearing after reset.
// ----------------------------------------------------------------------------
module min_tracking_stack #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // rec_id [15:0], rec_hours [27:16], zero fill
  input  logic [31:0]             s_axis_tdata_i,
  // kind [1:0]
  input  logic [1:0]              s_axis_tuser_i,
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // item_id, item_hours, least_id, least_hours, depth_now, status, zero fill
  // (depth_now is $clog2(DEPTH+1) bits; at DEPTH 16: [15:0], [27:16],
  //  [43:28], [55:44], [60:56], [62:61])
  output logic [((58 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata_o
);
  import mts_pkg::*;

  localparam int unsigned FW    = $clog2(DEPTH + 1);
  localparam int unsigned RES_W = 2 * (IdW + HoursW) + FW + 2;
  localparam int unsigned OUT_W = ((58 + FW + 7) / 8) * 8;

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  rec_t          rec_in, item, least;
  logic [FW-1:0] depth;
  logic [1:0]    status;

  assign rec_in.id    = s_axis_tdata_i[IdW-1:0];
  assign rec_in.hours = s_axis_tdata_i[IdW +: HoursW];

  // sequencer: handshake and pop reload steps
  mts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // stores, caches and result register
  mts_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .kind_i   (s_axis_tuser_i),
    .rec_i    (rec_in),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .item_o   (item),
    .least_o  (least),
    .depth_o  (depth),
    .status_o (status)
  );

  // pack fields from the lowest bit up
  assign m_axis_tdata_o = {{(OUT_W - RES_W){1'b0}}, status, depth,
                           least.hours, least.id, item.hours, item.id};

  // ---- checks ---------------------------------------------------------------

  // depth reported never exceeds the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (depth <= FW'(DEPTH)))
    else $error("depth beyond capacity");

  // a dropped push only happens on a full stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (status == STAT_OVER)) |-> (depth == FW'(DEPTH)))
    else $error("overflow reported below capacity");

  // underflow leaves an empty stack with cleared minimum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (status == STAT_UNDER)) |->
      ((depth == '0) && (least.hours == '0) && (least.id == '0)))
    else $error("underflow with records or minimum present");

  // a word that needs no reload gives its result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.take && !stat.reload) |=> m_axis_tvalid_o)
    else $error("result missing after single-cycle word");

endmodule
